[hw/rtl/mcls_pkg.sv]
// Shared types, token codes and helper functions for the mini C scanner.
package mcls_pkg;

  localparam int IdLimit  = 12;
  localparam int StoreMax = 11;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_DEC, M_ZERO, M_OCT, M_HEX, M_OP, M_LINE, M_BLOCK, M_BSTAR
  } scan_mode_t;

  localparam logic [5:0] TOK_IDENT  = 6'd4;
  localparam logic [5:0] TOK_NUMBER = 6'd5;
  localparam logic [5:0] TOK_EOF    = 6'd29;
  localparam logic [5:0] TOK_CONST  = 6'd30;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_LONG = 3'd1;
  localparam logic [2:0] ERR_AMP  = 3'd2;
  localparam logic [2:0] ERR_BAR  = 3'd3;
  localparam logic [2:0] ERR_CHAR = 3'd4;

  // One result word; 135 bits including last_result.
  typedef struct packed {
    logic        last_result;
    logic [2:0]  error_code;
    logic [3:0]  ident_len;
    logic [23:0] id_chars_high;
    logic [63:0] id_chars_low;
    logic [31:0] number_value;
    logic [5:0]  token_code;
    logic        token_valid;
  } result_t;

  // Pending token kind, handed from the front stage to the back stage.
  typedef enum logic [1:0] { P_NONE, P_IDENT, P_NUM, P_OP } pend_kind_t;

  typedef struct packed {
    pend_kind_t  kind;
    logic [7:0]  op;
    logic [87:0] id_buf;
    logic [3:0]  id_cnt;
    logic        id_ovf;
    logic [31:0] num;
  } pend_t;

  // Second result: the current byte's own outcome (punctuation, two-character operator or bad character).
  typedef struct packed {
    logic       has;
    logic       valid;
    logic [5:0] code;
    logic [2:0] err;
  } own_t;

  typedef struct packed {
    pend_t pend;
    own_t  own;
    logic  eof;
  } job_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_op_start(input logic [7:0] c);
    return c == "/" || c == "!" || c == "%" || c == "&" || c == "*" || c == "+" ||
           c == "-" || c == "<" || c == "=" || c == ">" || c == "|";
  endfunction

  // Single-character meaning of an operator: {valid, code, err}.
  function automatic logic [9:0] op_single(input logic [7:0] p);
    logic [9:0] r;
    unique case (p)
      "!":     r = {1'b1, 6'd0,  ERR_NONE};
      "%":     r = {1'b1, 6'd2,  ERR_NONE};
      "*":     r = {1'b1, 6'd9,  ERR_NONE};
      "<":     r = {1'b1, 6'd21, ERR_NONE};
      "=":     r = {1'b1, 6'd23, ERR_NONE};
      ">":     r = {1'b1, 6'd25, ERR_NONE};
      "+":     r = {1'b1, 6'd11, ERR_NONE};
      "-":     r = {1'b1, 6'd15, ERR_NONE};
      "/":     r = {1'b1, 6'd18, ERR_NONE};
      "&":     r = {1'b0, 6'd0,  ERR_AMP};
      "|":     r = {1'b0, 6'd0,  ERR_BAR};
      default: r = {1'b0, 6'd0,  ERR_CHAR};
    endcase
    return r;
  endfunction

  // Two-character operator: {hit, code}.
  function automatic logic [6:0] op_pair(input logic [7:0] p, input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c == "=") begin
      unique case (p)
        "!":     r = {1'b1, 6'd1};
        "%":     r = {1'b1, 6'd3};
        "*":     r = {1'b1, 6'd10};
        "<":     r = {1'b1, 6'd22};
        "=":     r = {1'b1, 6'd24};
        ">":     r = {1'b1, 6'd26};
        "+":     r = {1'b1, 6'd13};
        "-":     r = {1'b1, 6'd17};
        "/":     r = {1'b1, 6'd19};
        default: r = 7'd0;
      endcase
    end
    if (p == "+" && c == "+") r = {1'b1, 6'd12};
    if (p == "-" && c == "-") r = {1'b1, 6'd16};
    if (p == "&" && c == "&") r = {1'b1, 6'd6};
    if (p == "|" && c == "|") r = {1'b1, 6'd38};
    return r;
  endfunction

  // Punctuation that is a token by itself: {hit, code}.
  function automatic logic [6:0] punct(input logic [7:0] c);
    logic [6:0] r;
    unique case (c)
      "(":     r = {1'b1, 6'd7};
      ")":     r = {1'b1, 6'd8};
      ",":     r = {1'b1, 6'd14};
      ";":     r = {1'b1, 6'd20};
      "[":     r = {1'b1, 6'd27};
      "]":     r = {1'b1, 6'd28};
      "{":     r = {1'b1, 6'd37};
      "}":     r = {1'b1, 6'd39};
      default: r = 7'd0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/mini_c_lexical_scanner.sv]
// Top level of the mini C scanner: front stage, job queue, back stage.
// Usage:
//   Input stream s_axis: one source byte per word in s_axis_tdata[7:0]; s_axis_tuser
//   set marks end of source (byte ignored). A word is taken when tvalid and tready.
//   Output stream m_axis: one token or error per word. tdata packs, low bit up,
//   token_valid, token_code, number_value, id_chars_low, id_chars_high, ident_len,
//   error_code; tlast marks the final result caused by one input byte.
// Throughput: one byte per cycle while the job queue has room; a byte that closes a pending
//   token and is a token itself yields two words and holds the back stage until both are sent.
// Path: an accepted job is written into the queue register, then the back stage registers
//   its first word from the queue head into the output register.
// Reset: rst clears the scan state, the queue and the output valid flag.
// Stall: when m_axis_tready is low the output word holds, the two-entry queue
//   fills, then s_axis_tready drops; bytes that yield nothing still need room.
// End of source returns all scan state to reset so a new source may follow.
module mini_c_lexical_scanner
  import mcls_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // char_code
  input  logic         s_axis_tuser,  // end_of_input
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,  // token_valid, token_code, number_value,
                                      // id_chars_low, id_chars_high, ident_len, error_code
  output logic         m_axis_tlast   // last_result
);

  logic    fq_valid, fq_ready, qb_valid, qb_ready;
  job_t    fq_job, qb_job;
  result_t res;

  mcls_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .char_code(s_axis_tdata), .end_of_input(s_axis_tuser),
    .job_valid(fq_valid), .job(fq_job), .job_ready(fq_ready)
  );

  mcls_queue u_queue (
    .clk, .rst,
    .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fq_job),
    .out_valid(qb_valid), .out_job(qb_job), .out_ready(qb_ready)
  );

  mcls_back u_back (
    .clk, .rst,
    .job_valid(qb_valid), .job(qb_job), .job_ready(qb_ready),
    .res_valid(m_axis_tvalid), .res(res), .res_ready(m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, res.error_code, res.ident_len, res.id_chars_high,
                         res.id_chars_low, res.number_value, res.token_code,
                         res.token_valid};
  assign m_axis_tlast = res.last_result;

endmodule

[hw/rtl/mcls_front.sv]
// Front stage: runs the scan state per byte and emits a job for each byte that yields results.
module mcls_front
  import mcls_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       end_of_input,
  output logic       job_valid,
  output job_t       job,
  input  logic       job_ready
);

  scan_mode_t  mode, mode_next;
  logic [7:0]  op, op_next;
  logic [87:0] id_buf, id_buf_next;
  logic [3:0]  id_cnt, id_cnt_next;
  logic        id_ovf, id_ovf_next;
  logic [31:0] num, num_next;

  logic        take;
  logic [7:0]  c;
  logic        idle_go;
  logic [6:0]  pair, pun;
  logic [4:0]  hv;

  assign in_ready = job_ready;
  assign take     = in_valid && in_ready;
  assign c        = char_code;

  always_comb begin
    mode_next   = mode;
    op_next     = op;
    id_buf_next = id_buf;
    id_cnt_next = id_cnt;
    id_ovf_next = id_ovf;
    num_next    = num;
    job         = '0;
    job_valid   = 1'b0;
    idle_go     = 1'b0;
    pair        = op_pair(op, c);
    pun         = punct(c);
    hv          = 5'd0;
    if (is_digit(c))                  hv = {1'b1, c[3:0]};
    else if (c >= "a" && c <= "f")    hv = {1'b1, c[3:0] + 4'd9};
    else if (c >= "A" && c <= "F")    hv = {1'b1, c[3:0] + 4'd9};

    job.pend.op     = op;
    job.pend.id_buf = id_buf;
    job.pend.id_cnt = id_cnt;
    job.pend.id_ovf = id_ovf;
    job.pend.num    = num;

    if (end_of_input) begin
      job.eof = 1'b1;
      unique case (mode)
        M_IDENT:               job.pend.kind = P_IDENT;
        M_DEC, M_OCT, M_HEX:   job.pend.kind = P_NUM;
        M_ZERO: begin
          job.pend.kind = P_NUM;
          job.pend.num  = '0;
        end
        M_OP:                  job.pend.kind = P_OP;
        default:               job.pend.kind = P_NONE;
      endcase
      mode_next   = M_IDLE;
      op_next     = '0;
      id_buf_next = '0;
      id_cnt_next = '0;
      id_ovf_next = 1'b0;
      num_next    = '0;
    end else begin
      unique case (mode)
        M_IDENT:
          if (is_letter(c) || is_digit(c)) begin
            if (id_cnt >= 4'(IdLimit - 1)) id_ovf_next = 1'b1;
            else begin
              if (id_cnt < 4'(StoreMax)) id_buf_next[id_cnt[3:0]*8 +: 8] = c;
              id_cnt_next = id_cnt + 4'd1;
            end
          end else begin
            job.pend.kind = P_IDENT;
            idle_go = 1'b1;
          end
        M_DEC:
          if (is_digit(c)) num_next = (num << 3) + (num << 1) + {28'd0, c[3:0]};
          else begin
            job.pend.kind = P_NUM;
            idle_go = 1'b1;
          end
        M_ZERO:
          if (c >= "0" && c <= "7") begin
            num_next  = {29'd0, c[2:0]};
            mode_next = M_OCT;
          end else if (c == "x" || c == "X") begin
            num_next  = '0;
            mode_next = M_HEX;
          end else begin
            job.pend.kind = P_NUM;
            job.pend.num  = '0;
            idle_go = 1'b1;
          end
        M_OCT:
          if (c >= "0" && c <= "7") num_next = {num[28:0], c[2:0]};
          else begin
            job.pend.kind = P_NUM;
            idle_go = 1'b1;
          end
        M_HEX:
          if (hv[4]) num_next = {num[27:0], hv[3:0]};
          else begin
            job.pend.kind = P_NUM;
            idle_go = 1'b1;
          end
        M_OP:
          if (op == "/" && c == "*") mode_next = M_BLOCK;
          else if (op == "/" && c == "/") mode_next = M_LINE;
          else if (pair[6]) begin
            job.own   = '{has: 1'b1, valid: 1'b1, code: pair[5:0], err: ERR_NONE};
            mode_next = M_IDLE;
          end else begin
            job.pend.kind = P_OP;
            idle_go = 1'b1;
          end
        M_LINE:  if (c == 8'h0a) mode_next = M_IDLE;
        M_BLOCK: if (c == "*") mode_next = M_BSTAR;
        M_BSTAR:
          if (c == "/") mode_next = M_IDLE;
          else if (c != "*") mode_next = M_BLOCK;
        default: idle_go = 1'b1;
      endcase

      if (idle_go) begin
        mode_next = M_IDLE;
        if (is_space(c)) begin
        end else if (is_letter(c)) begin
          id_buf_next       = '0;
          id_buf_next[7:0]  = c;
          id_cnt_next       = 4'd1;
          id_ovf_next       = 1'b0;
          mode_next         = M_IDENT;
        end else if (is_digit(c)) begin
          num_next  = {28'd0, c[3:0]};
          mode_next = (c == "0") ? M_ZERO : M_DEC;
        end else if (is_op_start(c)) begin
          op_next   = c;
          mode_next = M_OP;
        end else if (pun[6]) begin
          job.own = '{has: 1'b1, valid: 1'b1, code: pun[5:0], err: ERR_NONE};
        end else begin
          job.own = '{has: 1'b1, valid: 1'b0, code: 6'd0, err: ERR_CHAR};
        end
      end
    end
    job_valid = in_valid && (job.eof || job.own.has || job.pend.kind != P_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      op     <= '0;
      id_buf <= '0;
      id_cnt <= '0;
      id_ovf <= 1'b0;
      num    <= '0;
    end else if (take) begin
      mode   <= mode_next;
      op     <= op_next;
      id_buf <= id_buf_next;
      id_cnt <= id_cnt_next;
      id_ovf <= id_ovf_next;
      num    <= num_next;
    end
  end

endmodule

[hw/rtl/mcls_queue.sv]
// Two-entry job queue between front and back stages.
module mcls_queue
  import mcls_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  output job_t out_job,
  input  logic out_ready
);

  job_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_job   = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[hw/rtl/mcls_back.sv]
// Back stage: turns a job into one or two result words, with keyword match.
module mcls_back
  import mcls_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  input  job_t    job,
  output logic    job_ready,
  output logic    res_valid,
  output result_t res,
  input  logic    res_ready
);

  logic    phase;          // 1 once the pending word of this job has gone out while its own word is still to come
  result_t pend_res, own_res, cur;
  logic    has_pend, has_own, first_is_last, send, out_free;
  logic [9:0] sing;
  logic [5:0] kw;

  function automatic logic [5:0] keyword(input logic [87:0] b, input logic [3:0] n);
    logic [5:0] r;
    r = TOK_IDENT;
    if (n == 4'd5 && b[39:0] == {"t","s","n","o","c"}) r = TOK_CONST;
    if (n == 4'd4 && b[31:0] == {"e","s","l","e"})     r = TOK_CONST + 6'd1;
    if (n == 4'd2 && b[15:0] == {"f","i"})             r = TOK_CONST + 6'd2;
    if (n == 4'd3 && b[23:0] == {"t","n","i"})         r = TOK_CONST + 6'd3;
    if (n == 4'd6 && b[47:0] == {"n","r","u","t","e","r"}) r = TOK_CONST + 6'd4;
    if (n == 4'd4 && b[31:0] == {"d","i","o","v"})     r = TOK_CONST + 6'd5;
    if (n == 4'd5 && b[39:0] == {"e","l","i","h","w"}) r = TOK_CONST + 6'd6;
    return r;
  endfunction

  always_comb begin
    sing     = op_single(job.pend.op);
    kw       = keyword(job.pend.id_buf, job.pend.id_cnt);
    pend_res = '0;
    unique case (job.pend.kind)
      P_IDENT: begin
        pend_res.token_valid = 1'b1;
        if (!job.pend.id_ovf && kw != TOK_IDENT) pend_res.token_code = kw;
        else begin
          pend_res.token_code    = TOK_IDENT;
          pend_res.error_code    = job.pend.id_ovf ? ERR_LONG : ERR_NONE;
          pend_res.id_chars_low  = job.pend.id_buf[63:0];
          pend_res.id_chars_high = job.pend.id_buf[87:64];
          pend_res.ident_len     = job.pend.id_cnt;
        end
      end
      P_NUM: begin
        pend_res.token_valid  = 1'b1;
        pend_res.token_code   = TOK_NUMBER;
        pend_res.number_value = job.pend.num;
      end
      P_OP: begin
        pend_res.token_valid = sing[9];
        pend_res.token_code  = sing[8:3];
        pend_res.error_code  = sing[2:0];
      end
      default: pend_res = '0;
    endcase
    own_res = '0;
    if (job.eof) begin
      own_res.token_valid = 1'b1;
      own_res.token_code  = TOK_EOF;
    end else begin
      own_res.token_valid = job.own.valid;
      own_res.token_code  = job.own.code;
      own_res.error_code  = job.own.err;
    end
    own_res.last_result = 1'b1;
    has_pend      = job.pend.kind != P_NONE && !phase;
    has_own       = job.eof || job.own.has;
    first_is_last = !has_own;
    cur           = has_pend ? pend_res : own_res;
    if (has_pend) cur.last_result = first_is_last;
    out_free  = !res_valid || res_ready;
    send      = job_valid && out_free;
    job_ready = out_free && (!has_pend || !has_own);
  end

  always_ff @(posedge clk) begin
    if (send) res <= cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (out_free) res_valid <= job_valid;
      if (send) phase <= has_pend && has_own;
    end
  end

endmodule

[test/tb.sv]
// Self-checking testbench for the mini C scanner: directed table, then random source text.
`timescale 1ns / 100ps
module tb;
  import mcls_pkg::*;

  typedef struct packed {
    logic        valid;
    logic [5:0]  code;
    logic [31:0] num;
    logic [63:0] lo;
    logic [23:0] hi;
    logic [3:0]  len;
    logic [2:0]  err;
    logic        last;
  } tok_t;

  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    logic       has_fixed;
    tok_t       fixed;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'd0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         m_axis_tlast;

  mini_c_lexical_scanner dut (.*);

  always #4 clk = ~clk;

  // scanner model state
  scan_mode_t  sm;
  logic [7:0]  pend_op;
  logic [7:0]  idb [11];
  int          idn;
  logic        idovf;
  logic [31:0] acc;

  tok_t tok_q[$];
  int   errors = 0;
  int   idle_cycles = 0;
  bit   done = 1'b0;

  function automatic bit letter_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction
  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic tok_t mk(logic v, logic [5:0] code, logic [31:0] num, logic [2:0] err);
    tok_t t;
    t = '0;
    t.valid = v;
    t.code = v ? code : 6'd0;
    t.num = (v && code == TOK_NUMBER) ? num : 32'd0;
    t.err = err;
    return t;
  endfunction

  task automatic clear_scan();
    sm = M_IDLE; pend_op = 8'd0; idn = 0; idovf = 1'b0; acc = 32'd0;
    foreach (idb[i]) idb[i] = 8'd0;
  endtask

  task automatic push_word(ref tok_t ws[$], input tok_t t);
    ws.push_back(t);
  endtask

  task automatic close_word(ref tok_t ws[$]);
    tok_t t;
    string kw [7];
    bit hit;
    int k;
    kw = '{"const", "else", "if", "int", "return", "void", "while"};
    hit = 0;
    if (!idovf) begin
      for (k = 0; k < 7; k++) begin
        if (idn == kw[k].len()) begin
          hit = 1;
          for (int j = 0; j < idn; j++) if (idb[j] != kw[k][j]) hit = 0;
          if (hit) break;
        end
      end
    end
    if (hit) begin
      push_word(ws, mk(1'b1, TOK_CONST + k[5:0], 32'd0, ERR_NONE));
    end else begin
      t = mk(1'b1, TOK_IDENT, 32'd0, idovf ? ERR_LONG : ERR_NONE);
      for (int j = 0; j < idn && j < StoreMax; j++) begin
        if (j < 8) t.lo[8*j +: 8] = idb[j];
        else t.hi[8*(j-8) +: 8] = idb[j];
      end
      t.len = idn[3:0];
      push_word(ws, t);
    end
  endtask

  task automatic add_char(logic [7:0] c);
    if (idn >= IdLimit - 1) idovf = 1'b1;
    else begin
      if (idn < StoreMax) idb[idn] = c;
      idn++;
    end
  endtask

  task automatic close_op(ref tok_t ws[$]);
    logic [9:0] s;
    case (pend_op)
      "!": s = {1'b1, 6'd0, ERR_NONE};
      "%": s = {1'b1, 6'd2, ERR_NONE};
      "*": s = {1'b1, 6'd9, ERR_NONE};
      "<": s = {1'b1, 6'd21, ERR_NONE};
      "=": s = {1'b1, 6'd23, ERR_NONE};
      ">": s = {1'b1, 6'd25, ERR_NONE};
      "+": s = {1'b1, 6'd11, ERR_NONE};
      "-": s = {1'b1, 6'd15, ERR_NONE};
      "/": s = {1'b1, 6'd18, ERR_NONE};
      "&": s = {1'b0, 6'd0, ERR_AMP};
      "|": s = {1'b0, 6'd0, ERR_BAR};
      default: s = {1'b0, 6'd0, ERR_CHAR};
    endcase
    push_word(ws, mk(s[9], s[8:3], 32'd0, s[2:0]));
  endtask

  task automatic from_idle(logic [7:0] c, ref tok_t ws[$]);
    sm = M_IDLE;
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
    if (letter_c(c)) begin
      foreach (idb[i]) idb[i] = 8'd0;
      idn = 0; idovf = 1'b0; sm = M_IDENT;
      add_char(c);
    end else if (digit_c(c)) begin
      acc = {24'd0, c - 8'h30};
      sm = (c == "0") ? M_ZERO : M_DEC;
    end else begin
      case (c)
        "/", "!", "%", "&", "*", "+", "-", "<", "=", ">", "|": begin
          pend_op = c; sm = M_OP;
        end
        "(": push_word(ws, mk(1'b1, 6'd7, 32'd0, ERR_NONE));
        ")": push_word(ws, mk(1'b1, 6'd8, 32'd0, ERR_NONE));
        ",": push_word(ws, mk(1'b1, 6'd14, 32'd0, ERR_NONE));
        ";": push_word(ws, mk(1'b1, 6'd20, 32'd0, ERR_NONE));
        "[": push_word(ws, mk(1'b1, 6'd27, 32'd0, ERR_NONE));
        "]": push_word(ws, mk(1'b1, 6'd28, 32'd0, ERR_NONE));
        "{": push_word(ws, mk(1'b1, 6'd37, 32'd0, ERR_NONE));
        "}": push_word(ws, mk(1'b1, 6'd39, 32'd0, ERR_NONE));
        default: push_word(ws, mk(1'b0, 6'd0, 32'd0, ERR_CHAR));
      endcase
    end
  endtask

  function automatic int hexv(logic [7:0] c);
    if (digit_c(c)) return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // Scan one byte and return the result words it yields.
  task automatic scan_byte(logic [7:0] c, logic eoi, ref tok_t ws[$]);
    int hv;
    logic [6:0] pr;
    ws.delete();
    if (eoi) begin
      case (sm)
        M_IDENT: close_word(ws);
        M_DEC, M_OCT, M_HEX: push_word(ws, mk(1'b1, TOK_NUMBER, acc, ERR_NONE));
        M_ZERO: push_word(ws, mk(1'b1, TOK_NUMBER, 32'd0, ERR_NONE));
        M_OP: close_op(ws);
        default: ;
      endcase
      push_word(ws, mk(1'b1, TOK_EOF, 32'd0, ERR_NONE));
      clear_scan();
    end else begin
      case (sm)
        M_IDENT:
          if (letter_c(c) || digit_c(c)) add_char(c);
          else begin close_word(ws); from_idle(c, ws); end
        M_DEC:
          if (digit_c(c)) acc = acc * 10 + (c - "0");
          else begin
            push_word(ws, mk(1'b1, TOK_NUMBER, acc, ERR_NONE)); from_idle(c, ws);
          end
        M_ZERO:
          if (c >= "0" && c <= "7") begin acc = {24'd0, c - 8'h30}; sm = M_OCT; end
          else if (c == "x" || c == "X") begin acc = 32'd0; sm = M_HEX; end
          else begin
            push_word(ws, mk(1'b1, TOK_NUMBER, 32'd0, ERR_NONE)); from_idle(c, ws);
          end
        M_OCT:
          if (c >= "0" && c <= "7") acc = acc * 8 + (c - "0");
          else begin
            push_word(ws, mk(1'b1, TOK_NUMBER, acc, ERR_NONE)); from_idle(c, ws);
          end
        M_HEX: begin
          hv = hexv(c);
          if (hv >= 0) acc = acc * 16 + hv;
          else begin
            push_word(ws, mk(1'b1, TOK_NUMBER, acc, ERR_NONE)); from_idle(c, ws);
          end
        end
        M_OP: begin
          pr = 7'd0;
          if (c == "=") begin
            case (pend_op)
              "!": pr = {1'b1, 6'd1};
              "%": pr = {1'b1, 6'd3};
              "*": pr = {1'b1, 6'd10};
              "<": pr = {1'b1, 6'd22};
              "=": pr = {1'b1, 6'd24};
              ">": pr = {1'b1, 6'd26};
              "+": pr = {1'b1, 6'd13};
              "-": pr = {1'b1, 6'd17};
              "/": pr = {1'b1, 6'd19};
              default: ;
            endcase
          end
          if (pend_op == "+" && c == "+") pr = {1'b1, 6'd12};
          if (pend_op == "-" && c == "-") pr = {1'b1, 6'd16};
          if (pend_op == "&" && c == "&") pr = {1'b1, 6'd6};
          if (pend_op == "|" && c == "|") pr = {1'b1, 6'd38};
          if (pend_op == "/" && c == "*") sm = M_BLOCK;
          else if (pend_op == "/" && c == "/") sm = M_LINE;
          else if (pr[6]) begin
            push_word(ws, mk(1'b1, pr[5:0], 32'd0, ERR_NONE)); sm = M_IDLE;
          end
          else begin close_op(ws); from_idle(c, ws); end
        end
        M_LINE: if (c == 8'h0a) sm = M_IDLE;
        M_BLOCK: if (c == "*") sm = M_BSTAR;
        M_BSTAR:
          if (c == "/") sm = M_IDLE;
          else if (c != "*") sm = M_BLOCK;
        default: from_idle(c, ws);
      endcase
    end
    if (ws.size() > 0) ws[ws.size()-1].last = 1'b1;
  endtask

  // source feed
  logic [7:0] src_ch[$];
  logic       src_eoi[$];
  bit         src_fix[$];
  tok_t       src_tok[$];

  task automatic add_byte(logic [7:0] c, logic e);
    src_ch.push_back(c); src_eoi.push_back(e); src_fix.push_back(0); src_tok.push_back('0);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
  endtask

  row_t dir_rows[$];

  task automatic add_rows();
    row_t r;
    r.eoi = 1'b0; r.has_fixed = 1'b0; r.fixed = '0;
    // end right after reset: only the end token
    r.ch = 8'hff; r.eoi = 1'b1; r.has_fixed = 1'b1;
    r.fixed = mk(1'b1, TOK_EOF, 32'd0, ERR_NONE);
    r.fixed.last = 1'b1; dir_rows.push_back(r);
    r.eoi = 1'b0;
    r.ch = 8'h00; r.fixed = mk(1'b0, 6'd0, 32'd0, ERR_CHAR); r.fixed.last = 1'b1;
    dir_rows.push_back(r);
    r.ch = 8'hff; dir_rows.push_back(r);
    r.ch = 8'h80; dir_rows.push_back(r);
    r.ch = "@"; dir_rows.push_back(r);
    r.ch = "("; r.fixed = mk(1'b1, 6'd7, 32'd0, ERR_NONE); r.fixed.last = 1'b1;
    dir_rows.push_back(r);
    r.ch = "}"; r.fixed = mk(1'b1, 6'd39, 32'd0, ERR_NONE); r.fixed.last = 1'b1;
    dir_rows.push_back(r);
  endtask

  initial begin
    tok_t ws[$];
    string frag [24];
    int n, pick;
    frag = '{"int ", "while", "return", "const", "void", "else", "if", "abcdefghijk",
             "abcdefghijklmnop", "_x9", "4294967295", "4294967296", "0777", "0x1fFfFfFfF",
             "0xAbC", "09", "0", "+= ++ -- -= != == <= >= && || %= *= /=",
             "& | ! % * < > = + - /", "/* x ** y */", "// line\n", "( ) , ; [ ] { }",
             "\t\n\r\v\f ", "0x;"};
    add_rows();
    foreach (dir_rows[i]) begin
      src_ch.push_back(dir_rows[i].ch); src_eoi.push_back(dir_rows[i].eoi);
      src_fix.push_back(dir_rows[i].has_fixed); src_tok.push_back(dir_rows[i].fixed);
    end
    add_text("&x|y 0x 09 0 /*a*/b"); add_byte(8'd0, 1'b1);
    add_text("/* open"); add_byte(8'd0, 1'b1);
    add_text("abcdefghijklmno"); add_byte(8'd0, 1'b1);
    n = src_ch.size();
    while (src_ch.size() < n + 900) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) add_text(frag[$urandom_range(0, 23)]);
      else if (pick == 7) add_byte(8'($urandom_range(0, 255)), 1'b0);
      else if (pick == 8) add_text(" ");
      else add_byte(8'($urandom_range(0, 255)), 1'b1);
    end
    add_byte(8'd0, 1'b1);

    clear_scan();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < src_ch.size(); i++) begin
      // one quiet pause mid-run until everything has drained
      if (i == src_ch.size() / 2) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (tok_q.size() > 0);
      end else if (i > 30 && i % 120 != 0) begin
        repeat ($urandom_range(0, 18) * ($urandom_range(0, 3) == 0)) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk);
        end
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= src_ch[i];
      s_axis_tuser <= src_eoi[i];
      do @(posedge clk); while (!s_axis_tready);
      scan_byte(src_ch[i], src_eoi[i], ws);
      if (src_fix[i] && (ws.size() != 1 || ws[0] != src_tok[i])) begin
        errors++;
        $display("table row %0d: model disagrees with fixed expectation", i);
      end
      foreach (ws[k]) tok_q.push_back(ws[k]);
    end
    s_axis_tvalid <= 1'b0;
    while (tok_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    done = 1'b1;
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // sink: random stalls, one long hold-off
  initial begin
    int hold;
    m_axis_tready <= 1'b0;
    @(negedge rst);
    repeat (60) @(posedge clk);
    repeat (200) @(posedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      hold = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 18)) : 0;
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // check every accepted word
  always @(posedge clk) begin
    tok_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[0], m_axis_tdata[6:1], m_axis_tdata[38:7], m_axis_tdata[102:39],
             m_axis_tdata[126:103], m_axis_tdata[130:127], m_axis_tdata[133:131],
             m_axis_tlast};
      if (tok_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", got);
      end else begin
        want = tok_q.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: expected v%0d c%0d n%h lo%h hi%h l%0d e%0d t%0d,",
                      " got v%0d c%0d n%h lo%h hi%h l%0d e%0d t%0d"},
                     want.valid, want.code, want.num, want.lo, want.hi, want.len, want.err,
                     want.last, got.valid, got.code, got.num, got.lo, got.hi, got.len,
                     got.err, got.last);
        end
      end
    end
  end

  // watchdog on cycles with no accepted word on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!done && idle_cycles > 2000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end
endmodule
